/* hdl/assert_macros.svh */
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hdl/pcs_pkg.sv */
package pcs_pkg;
   localparam int MaxBins = 1024;
   localparam int IdxBits = 10;
   localparam int CntBits = 11;
   localparam int WeightBits = 16;
   localparam int FracBits = 24;
   localparam int SumBits = 26;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_DENSITY = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  bin_index;
      logic [15:0] weight;
      logic [23:0] u;
   } req_type;

   typedef struct packed {
      logic [23:0] x;
      logic [31:0] density;
      logic [9:0]  bin;
      logic        degenerate;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_LDRD, ST_LDWR, ST_TOTRD, ST_TOTWR,
      ST_SRCH, ST_SRCHW, ST_EDGE, ST_EDGEW, ST_DIV, ST_WRD, ST_WRDW, ST_DDIV, ST_DONE
   } state_type;
endpackage

/* hdl/piecewise_constant_1d_sampler.sv */
// Inverse-CDF sampler over up to 1024 piecewise-constant bins. Loads store a
// bin weight and the next prefix sum; samples binary-search the prefix-sum
// memory (one read per step), then run a 50-step restoring divider for the
// in-bin fraction, a 50-step divider for x and a 50-step divider for density.
// After reset a clearing pass zeroes all 1025 entries of the prefix-sum memory
// before the first transaction is taken. Writing bins_in_use rereads the total
// (csr_ready low meanwhile); csr_ready stays low while req_valid is high.
module piecewise_constant_1d_sampler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcs_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [10:0]       csr_data
);
   // memories
   logic [15:0] wmem [pcs_pkg::MaxBins];
   logic [25:0] pmem [pcs_pkg::MaxBins + 1];
   logic [10:0] prd_addr, pwr_addr;
   logic [9:0]  wrd_addr;
   logic [25:0] prd_q, pwr_data;
   logic [15:0] wrd_q;
   logic        pwr_en, wwr_en;

   pcs_pkg::state_type state_ff, state_in;
   pcs_pkg::req_type   req_ff, req_in;
   pcs_pkg::rsp_type   rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] nbins_ff, nbins_in, n_eff;
   logic [25:0] total_ff, total_in;
   logic [10:0] cnt_ff, cnt_in;
   logic [10:0] first_ff, first_in, len_ff, len_in, mid;
   logic [25:0] pb_ff, pb_in;
   logic [49:0] tgt_ff, tgt_in;
   logic [49:0] quo_ff, quo_in;
   logic [50:0] rem_ff, rem_in;
   logic [49:0] dvd_ff, dvd_in;
   logic [25:0] dvs_ff, dvs_in;
   logic [5:0]  step_ff, step_in;
   logic [9:0]  bsel_ff, bsel_in;
   logic        degen;
   logic [50:0] rem_sh;

   always_ff @(posedge clock) begin
      if (pwr_en) pmem[pwr_addr] <= pwr_data;
      prd_q <= pmem[prd_addr];
      if (wwr_en) wmem[req_ff.bin_index] <= req_ff.weight;
      wrd_q <= wmem[wrd_addr];
   end

   assign n_eff = (nbins_ff == 11'd0) ? 11'd1 :
                  (nbins_ff > 11'd1024) ? 11'd1024 : nbins_ff;
   assign degen = (total_ff == 26'd0);
   assign mid = first_ff + (len_ff >> 1);
   assign rem_sh = {rem_ff[49:0], dvd_ff[49]};

   assign req_ready = (state_ff == pcs_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = (state_ff == pcs_pkg::ST_IDLE) && !rsp_valid_ff && !req_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcs_pkg::ST_CLEAR: if (cnt_ff == 11'd1024) state_in = pcs_pkg::ST_IDLE;
         pcs_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_data.op)
                  pcs_pkg::OP_LOAD: state_in = pcs_pkg::ST_LDRD;
                  pcs_pkg::OP_SAMPLE: state_in = pcs_pkg::ST_SRCH;
                  pcs_pkg::OP_DENSITY: state_in = pcs_pkg::ST_WRD;
                  default: state_in = pcs_pkg::ST_DONE;
               endcase
            end else if (csr_valid && csr_ready) state_in = pcs_pkg::ST_TOTRD;
         end
         pcs_pkg::ST_LDRD: state_in = pcs_pkg::ST_LDWR;
         pcs_pkg::ST_LDWR: state_in = pcs_pkg::ST_TOTRD;
         pcs_pkg::ST_TOTRD: state_in = pcs_pkg::ST_TOTWR;
         pcs_pkg::ST_TOTWR: state_in = (req_ff.op == pcs_pkg::OP_LOAD) ?
                               pcs_pkg::ST_DONE : pcs_pkg::ST_IDLE;
         pcs_pkg::ST_SRCH: state_in = (len_ff == 11'd0) ? pcs_pkg::ST_EDGE :
                                      pcs_pkg::ST_SRCHW;
         pcs_pkg::ST_SRCHW: state_in = pcs_pkg::ST_SRCH;
         pcs_pkg::ST_EDGE: state_in = pcs_pkg::ST_EDGEW;
         pcs_pkg::ST_EDGEW: state_in = (cnt_ff == 11'd1) ? pcs_pkg::ST_DIV :
                                       pcs_pkg::ST_EDGE;
         pcs_pkg::ST_DIV: if (step_ff == 6'd0) state_in = (cnt_ff == 11'd2) ?
                             pcs_pkg::ST_WRD : pcs_pkg::ST_DIV;
         pcs_pkg::ST_WRD: state_in = pcs_pkg::ST_WRDW;
         pcs_pkg::ST_WRDW: state_in = pcs_pkg::ST_DDIV;
         pcs_pkg::ST_DDIV: if (step_ff == 6'd0) state_in = pcs_pkg::ST_DONE;
         pcs_pkg::ST_DONE: state_in = pcs_pkg::ST_IDLE;
         default: state_in = pcs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff; rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      nbins_in = nbins_ff; total_in = total_ff; cnt_in = cnt_ff;
      first_in = first_ff; len_in = len_ff; pb_in = pb_ff; tgt_in = tgt_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvd_in = dvd_ff; dvs_in = dvs_ff;
      step_in = step_ff; bsel_in = bsel_ff;
      prd_addr = n_eff; pwr_addr = cnt_ff; pwr_data = 26'd0; pwr_en = 1'b0;
      wwr_en = 1'b0; wrd_addr = bsel_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         pcs_pkg::ST_CLEAR: begin
            pwr_en = 1'b1; cnt_in = cnt_ff + 11'd1;
         end
         pcs_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               rsp_in = '0;
               first_in = 11'd1; len_in = n_eff - 11'd1;
               tgt_in = {26'd0, req_data.u} * (degen ? {15'd0, n_eff} : total_ff);
               prd_addr = {1'b0, req_data.bin_index};
            end else if (csr_valid && csr_ready) begin
               nbins_in = csr_data;
               req_in.op = pcs_pkg::OP_UNUSED;
            end
         end
         // hold the read on the prefix entry of the loaded bin
         pcs_pkg::ST_LDRD: prd_addr = {1'b0, req_ff.bin_index};
         pcs_pkg::ST_LDWR: begin
            pwr_addr = {1'b0, req_ff.bin_index} + 11'd1;
            pwr_data = prd_q + {10'd0, req_ff.weight};
            pwr_en = 1'b1; wwr_en = 1'b1;
         end
         pcs_pkg::ST_TOTWR: total_in = prd_q;
         pcs_pkg::ST_SRCH: begin
            prd_addr = mid;
            cnt_in = 11'd0;
            if (len_ff == 11'd0)
               bsel_in = (first_ff - 11'd1 > n_eff - 11'd1) ? 10'(n_eff - 11'd1) :
                         10'(first_ff - 11'd1);
         end
         pcs_pkg::ST_SRCHW: begin
            if ((degen ? {15'd0, mid} : prd_q) <= tgt_ff[49:24]) begin
               first_in = mid + 11'd1; len_in = len_ff - (len_ff >> 1) - 11'd1;
            end else len_in = len_ff >> 1;
         end
         pcs_pkg::ST_EDGE: prd_addr = {1'b0, bsel_ff} + {10'd0, cnt_ff[0]};
         pcs_pkg::ST_EDGEW: begin
            cnt_in = cnt_ff + 11'd1;
            if (cnt_ff == 11'd0) pb_in = degen ? {16'd0, bsel_ff} : prd_q;
            else begin
               // width and numerator of the in-bin fraction
               dvs_in = (degen ? 26'({bsel_ff} + 11'd1) : prd_q) - pb_ff;
               dvd_in = ((degen ? 26'({bsel_ff} + 11'd1) : prd_q) > pb_ff &&
                         tgt_ff >= {pb_ff, 24'd0}) ? tgt_ff - {pb_ff, 24'd0} : '0;
               if (!((degen ? 26'({bsel_ff} + 11'd1) : prd_q) > pb_ff)) dvs_in = '0;
               rem_in = '0; quo_in = '0; step_in = 6'd50; cnt_in = 11'd1;
            end
         end
         pcs_pkg::ST_DIV: begin
            if (step_ff != 6'd0) begin
               if (rem_sh >= {25'd0, dvs_ff}) begin
                  rem_in = rem_sh - {25'd0, dvs_ff}; quo_in = {quo_ff[48:0], 1'b1};
               end else begin
                  rem_in = rem_sh; quo_in = {quo_ff[48:0], 1'b0};
               end
               dvd_in = {dvd_ff[48:0], 1'b0};
               step_in = step_ff - 6'd1;
            end else if (cnt_ff == 11'd1) begin
               // clamp du, then divide bin*2^24+du by n
               dvd_in = {16'd0, bsel_ff, 24'd0} +
                        ((dvs_ff == '0) ? 50'd0 :
                         (quo_ff > 50'hFFFFFF) ? 50'hFFFFFF : quo_ff);
               dvs_in = {15'd0, n_eff};
               rem_in = '0; quo_in = '0; step_in = 6'd50; cnt_in = 11'd2;
            end else begin
               rsp_in.x = (quo_ff > 50'hFFFFFF) ? 24'hFFFFFF : quo_ff[23:0];
            end
         end
         pcs_pkg::ST_WRD: begin
            if (req_ff.op == pcs_pkg::OP_DENSITY) begin
               bsel_in = 10'((({26'd0, req_ff.u} * {39'd0, n_eff}) >> 24) > {39'd0, n_eff - 11'd1} ?
                         n_eff - 11'd1 : 11'(({26'd0, req_ff.u} * {39'd0, n_eff}) >> 24));
               wrd_addr = 10'((({26'd0, req_ff.u} * {39'd0, n_eff}) >> 24) > {39'd0, n_eff - 11'd1} ?
                         n_eff - 11'd1 : 11'(({26'd0, req_ff.u} * {39'd0, n_eff}) >> 24));
            end
         end
         pcs_pkg::ST_WRDW: begin
            rsp_in.bin = bsel_ff;
            dvd_in = {8'd0, 16'd0, 26'(wrd_q * {5'd0, n_eff})} << 16;
            dvs_in = total_ff; rem_in = '0; quo_in = '0; step_in = 6'd50;
         end
         pcs_pkg::ST_DDIV: begin
            if (step_ff != 6'd0) begin
               if (rem_sh >= {25'd0, dvs_ff}) begin
                  rem_in = rem_sh - {25'd0, dvs_ff}; quo_in = {quo_ff[48:0], 1'b1};
               end else begin
                  rem_in = rem_sh; quo_in = {quo_ff[48:0], 1'b0};
               end
               dvd_in = {dvd_ff[48:0], 1'b0};
               step_in = step_ff - 6'd1;
            end else rsp_in.density = degen ? 32'hFFFFFFFF :
                        (quo_ff > 50'hFFFFFFFF) ? 32'hFFFFFFFF : quo_ff[31:0];
         end
         pcs_pkg::ST_DONE: begin
            rsp_in.degenerate = degen; rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcs_pkg::ST_CLEAR; rsp_valid_ff <= 1'b0;
         nbins_ff <= 11'd1024; total_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         nbins_ff <= nbins_in; total_ff <= total_in; cnt_ff <= cnt_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; first_ff <= first_in; len_ff <= len_in;
      pb_ff <= pb_in; tgt_ff <= tgt_in; quo_ff <= quo_in; rem_ff <= rem_in;
      dvd_ff <= dvd_in; dvs_ff <= dvs_in; step_ff <= step_in; bsel_ff <= bsel_in;
   end
endmodule

/* hdl/pcs_checker.sv */
`include "assert_macros.svh"
module pcs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pcs_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   `ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `ASSERT_IMPL(a_no_take_busy, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(a_csr_when_idle, clock, reset, csr_ready, req_ready)
endmodule

bind piecewise_constant_1d_sampler pcs_checker u_pcs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
   .csr_ready(csr_ready)
);
